>>> hdl/ntmpd_pkg.sv
package ntmpd_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int STORED_ROWS   = 4;
    localparam int RING_ROWS     = 2 * STORED_ROWS;
    localparam int RING_W        = $clog2(RING_ROWS);
    localparam int PIX_W         = 24;
    localparam int CH_W          = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 12;
    localparam int IMG_W_W       = 11;
    localparam int IMG_H_W       = 12;
    localparam int COL_W         = 12;
    localparam int W_W           = 13;
    localparam int ROW_W         = 13;
    localparam int POS_W         = 24;
    localparam int SUM_W         = 12;
    localparam int DIST_W        = 10;
    localparam int MIN_SIDE      = 5;
    localparam int MAX_HEIGHT    = 4095;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int WIN_SMALL     = 9;
    localparam int WIN_LARGE     = 13;
    localparam int RECIP_SMALL   = 7282;
    localparam int RECIP_LARGE   = 5042;
    localparam int RECIP_SH      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WRITE,
        B_READ,
        B_MEAN,
        B_SCAN,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic              wr;
        logic [RING_W-1:0] wr_row;
        logic [COL_W-1:0]  wr_col;
        logic              emit;
        logic              filt;
        logic              frame_end;
        logic [RING_W-1:0] out_row;
        logic [COL_W-1:0]  out_col;
    } cmd_t;

    function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] p, input int k);
        chan = p[k*CH_W +: CH_W];
    endfunction

    function automatic logic [DIST_W-1:0] l1_dist(input logic [PIX_W-1:0] p,
                                                  input logic [PIX_W-1:0] m);
        logic [DIST_W-1:0] d;
        logic [CH_W-1:0]   a;
        logic [CH_W-1:0]   b;
        d = '0;
        for (int c = 0; c < 3; c++)
        begin
            a = p[c*CH_W +: CH_W];
            b = m[c*CH_W +: CH_W];
            d = d + DIST_W'((a > b) ? (a - b) : (b - a));
        end
        l1_dist = d;
    endfunction

endpackage

>>> hdl/nearest_to_mean_pixel_denoise_unit.sv
// channel   dir  width  contents
// s_axis    in   24+1   pixel bytes in tdata, filler flag in tuser
// m_axis    out  24+1   filtered pixel bytes in tdata, frame end in tlast
// cfg       in   1+12   register index and write data, one write per cycle
//
// a filtered pixel passes through the back end as one pop, one store write,
// thirteen reads through the single, registered row store read port, one mean
// step, thirteen distance compare steps and one write-back; border pixels make
// one read and skip the mean and compare steps; items that only store a pixel
// are a pop and a store write; flush items skip the store write
// after a register write the input is held while the output
// position is re-divided by the new width
// rst_n clears counters, queue and output valid; the row store is not cleared
// input and output stall independently through the command queue and the
// output register
module nearest_to_mean_pixel_denoise_unit
    import ntmpd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // blue_in, green_in, red_in
    input  logic                  s_axis_tuser,  // filler
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,  // blue_out, green_out, red_out
    output logic                  m_axis_tlast   // frame_end
);

    cmd_t q_in;
    cmd_t q_out;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // front: position counters and per-transfer classification
    ntmpd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (s_axis_tdata),
        .in_filler (s_axis_tuser),
        .q_push    (q_push),
        .q_cmd     (q_in),
        .q_full    (q_full)
    );

    // two-entry command queue between front and back
    ntmpd_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_out),
        .empty    (q_empty)
    );

    // back: row store, window gather, nearest-to-mean pick, write-back
    ntmpd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (q_out),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pix   (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

>>> hdl/ntmpd_cmd_queue.sv
module ntmpd_cmd_queue
    import ntmpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_cmd = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

>>> hdl/ntmpd_front.sv
module ntmpd_front
    import ntmpd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      in_pix,
    input  logic                  in_filler,
    output logic                  q_push,
    output cmd_t                  q_cmd,
    input  logic                  q_full
);

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [W_W-1:0]     w;
    logic [IMG_H_W-1:0] h;
    logic [POS_W-1:0]   total_reg;

    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;

    // resync divider for out position after a register write
    logic [4:0]         div_cnt_reg;
    logic [POS_W-1:0]   div_num_reg;
    logic [COL_W-1:0]   div_rem_reg;
    logic [ROW_W-1:0]   div_quo_reg;
    logic [W_W-1:0]     div_try;
    logic               div_ge;
    logic [COL_W-1:0]   div_rem_next;
    logic [ROW_W-1:0]   div_quo_next;

    logic               accept;
    logic               clr;
    logic [COL_W-1:0]   c0;
    logic [ROW_W-1:0]   r0;
    logic [POS_W-1:0]   op;
    logic [ROW_W-1:0]   orow;
    logic [COL_W-1:0]   ocol;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               inframe;
    logic               drop;
    logic               emit;
    logic               filt;
    logic [POS_W-1:0]   op_n;
    logic               fend;
    logic [COL_W-1:0]   col_adv;
    logic [ROW_W-1:0]   row_adv;
    logic [COL_W-1:0]   ocol_adv;
    logic [ROW_W-1:0]   orow_adv;

    always_comb
    begin
        if ({2'b0, width_reg} < W_W'(MIN_SIDE))
            w = W_W'(MIN_SIDE);
        else if ({2'b0, width_reg} > W_W'(MAX_WIDTH))
            w = W_W'(MAX_WIDTH);
        else
            w = {2'b0, width_reg};
        if (height_reg < IMG_H_W'(MIN_SIDE))
            h = IMG_H_W'(MIN_SIDE);
        else
            h = height_reg;
    end

    assign in_ready = (div_cnt_reg == 5'd0) && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        div_try      = W_W'({div_rem_reg, div_num_reg[POS_W-1]});
        div_ge       = (div_try >= w);
        div_rem_next = div_ge ? COL_W'(div_try - w) : COL_W'(div_try);
        div_quo_next = {div_quo_reg[ROW_W-2:0], div_ge};
    end

    always_comb
    begin
        clr  = (out_pos_reg >= total_reg);
        c0   = clr ? '0 : in_col_reg;
        r0   = clr ? '0 : in_row_reg;
        op   = clr ? '0 : out_pos_reg;
        orow = clr ? '0 : out_row_reg;
        ocol = clr ? '0 : out_col_reg;
        if ({1'b0, c0} >= w)
        begin
            col = '0;
            row = r0 + ROW_W'(1);
        end
        else
        begin
            col = c0;
            row = r0;
        end
        inframe = (row < {1'b0, h});
        drop    = inframe && in_filler;
        if (({1'b0, col} + W_W'(1)) >= w)
        begin
            col_adv = '0;
            row_adv = row + ROW_W'(1);
        end
        else
        begin
            col_adv = col + COL_W'(1);
            row_adv = row;
        end
        emit = !((row < ROW_W'(2)) || ((row == ROW_W'(2)) && (col < COL_W'(2))));
        filt = (orow >= ROW_W'(2)) && (({1'b0, orow} + 14'd2) < {2'b0, h})
            && (ocol >= COL_W'(2)) && (({1'b0, ocol} + W_W'(2)) < w);
        op_n = op + POS_W'(1);
        fend = (op_n >= total_reg);
        if (({1'b0, ocol} + W_W'(1)) >= w)
        begin
            ocol_adv = '0;
            orow_adv = orow + ROW_W'(1);
        end
        else
        begin
            ocol_adv = ocol + COL_W'(1);
            orow_adv = orow;
        end
    end

    always_comb
    begin
        q_push          = accept && !drop && (inframe || emit);
        q_cmd.pix       = in_pix;
        q_cmd.wr        = inframe;
        q_cmd.wr_row    = row[RING_W-1:0];
        q_cmd.wr_col    = col;
        q_cmd.emit      = emit;
        q_cmd.filt      = filt;
        q_cmd.frame_end = fend;
        q_cmd.out_row   = orow[RING_W-1:0];
        q_cmd.out_col   = ocol;
    end

    always_ff @(posedge clk)
    begin
        total_reg <= POS_W'(w) * POS_W'(h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= IMG_W_W'(RESET_WIDTH);
            height_reg  <= IMG_H_W'(RESET_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_pos_reg <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            div_cnt_reg <= '0;
            div_num_reg <= '0;
            div_rem_reg <= '0;
            div_quo_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                    default:          ;
                endcase
                div_cnt_reg <= 5'(POS_W);
                div_num_reg <= out_pos_reg;
                div_rem_reg <= '0;
                div_quo_reg <= '0;
            end
            else if (div_cnt_reg != 5'd0)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
                div_num_reg <= {div_num_reg[POS_W-2:0], 1'b0};
                div_rem_reg <= div_rem_next;
                div_quo_reg <= div_quo_next;
                if (div_cnt_reg == 5'd1)
                begin
                    out_row_reg <= div_quo_next;
                    out_col_reg <= div_rem_next;
                end
            end
            else if (accept && !drop)
            begin
                if (emit && fend)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_pos_reg <= '0;
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
                else
                begin
                    in_col_reg <= col_adv;
                    in_row_reg <= row_adv;
                    if (emit)
                    begin
                        out_pos_reg <= op_n;
                        out_row_reg <= orow_adv;
                        out_col_reg <= ocol_adv;
                    end
                    else
                    begin
                        out_pos_reg <= op;
                        out_row_reg <= orow;
                        out_col_reg <= ocol;
                    end
                end
            end
        end
    end

endmodule

>>> hdl/ntmpd_back.sv
module ntmpd_back
    import ntmpd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pix,
    output logic             out_last
);

    localparam int DEPTH  = RING_ROWS * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int PROD_W = SUM_W + RECIP_SH;

    logic [PIX_W-1:0]  mem [DEPTH];
    logic [PIX_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [PIX_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cur_reg;
    logic [3:0]        cnt_reg;
    logic [3:0]        n_reads;
    logic [3:0]        idx;
    logic [PIX_W-1:0]  win_reg [WIN_LARGE];
    logic [SUM_W-1:0]  sum9_reg  [3];
    logic [SUM_W-1:0]  sum13_reg [3];
    logic [PIX_W-1:0]  mean9_reg;
    logic [PIX_W-1:0]  mean13_reg;
    logic [PIX_W-1:0]  best9_reg;
    logic [PIX_W-1:0]  best13_reg;
    logic [DIST_W-1:0] bd9_reg;
    logic [DIST_W-1:0] bd13_reg;
    logic [DIST_W-1:0] d9;
    logic [DIST_W-1:0] d13;
    logic [PIX_W-1:0]  res;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_last_reg;
    logic              out_free;
    logic [RING_W-1:0] dr;
    logic [2:0]        dc;
    logic [RING_W-1:0] rd_row;
    logic [COL_W-1:0]  rd_col;

    function automatic logic [AW-1:0] addr_of(input logic [RING_W-1:0] r,
                                              input logic [COL_W-1:0] c);
        addr_of = AW'(AW'(r) * AW'(MAX_WIDTH) + AW'(c));
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;
    assign n_reads   = cur_reg.filt ? 4'(WIN_LARGE) : 4'd1;
    assign idx       = cnt_reg - 4'd1;

    // window offsets: 3x3 in row order, then up, down, left, right by two
    always_comb
    begin
        unique case (cnt_reg)
            4'd0:    begin dr = 3'b111; dc = 3'b111; end
            4'd1:    begin dr = 3'b111; dc = 3'b000; end
            4'd2:    begin dr = 3'b111; dc = 3'b001; end
            4'd3:    begin dr = 3'b000; dc = 3'b111; end
            4'd4:    begin dr = 3'b000; dc = 3'b000; end
            4'd5:    begin dr = 3'b000; dc = 3'b001; end
            4'd6:    begin dr = 3'b001; dc = 3'b111; end
            4'd7:    begin dr = 3'b001; dc = 3'b000; end
            4'd8:    begin dr = 3'b001; dc = 3'b001; end
            4'd9:    begin dr = 3'b110; dc = 3'b000; end
            4'd10:   begin dr = 3'b010; dc = 3'b000; end
            4'd11:   begin dr = 3'b000; dc = 3'b110; end
            4'd12:   begin dr = 3'b000; dc = 3'b010; end
            default: begin dr = 3'b000; dc = 3'b000; end
        endcase
        if (cur_reg.filt)
        begin
            rd_row = cur_reg.out_row + dr;
            rd_col = cur_reg.out_col + {{(COL_W-3){dc[2]}}, dc};
        end
        else
        begin
            rd_row = cur_reg.out_row;
            rd_col = cur_reg.out_col;
        end
        mem_raddr = addr_of(rd_row, rd_col);
    end

    always_comb
    begin
        d9  = l1_dist(win_reg[0], mean9_reg);
        d13 = l1_dist(win_reg[0], mean13_reg);
        for (int c = 0; c < 3; c++)
        begin
            res[c*CH_W +: CH_W] = CH_W'(({1'b0, chan(best9_reg, c)}
                + {1'b0, chan(best13_reg, c)}) >> 1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                    state_next = q_cmd.wr ? B_WRITE : B_READ;
            end
            B_WRITE:
            begin
                state_next = cur_reg.emit ? B_READ : B_IDLE;
            end
            B_READ:
            begin
                if (cnt_reg == n_reads)
                    state_next = cur_reg.filt ? B_MEAN : B_DONE;
            end
            B_MEAN:
            begin
                state_next = B_SCAN;
            end
            B_SCAN:
            begin
                if (cnt_reg == 4'(WIN_LARGE - 1))
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == B_IDLE) && !q_empty;
        mem_we    = 1'b0;
        mem_waddr = addr_of(cur_reg.wr_row, cur_reg.wr_col);
        mem_wdata = cur_reg.pix;
        unique case (state_reg)
            B_WRITE:
            begin
                mem_we = 1'b1;
            end
            B_DONE:
            begin
                mem_we    = out_free;
                mem_waddr = addr_of(cur_reg.out_row, cur_reg.out_col);
                mem_wdata = res;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_cmd;
        end
        unique case (state_reg)
            B_READ:
            begin
                // first read cycle only issues the address, sums start over
                if (cnt_reg == 4'd0)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        sum9_reg[c]  <= '0;
                        sum13_reg[c] <= '0;
                    end
                end
                else
                begin
                    for (int i = 0; i < WIN_LARGE - 1; i++)
                    begin
                        win_reg[i] <= win_reg[i+1];
                    end
                    win_reg[WIN_LARGE-1] <= rd_data_reg;
                    for (int c = 0; c < 3; c++)
                    begin
                        sum13_reg[c] <= sum13_reg[c] + SUM_W'(chan(rd_data_reg, c));
                        if (idx < 4'(WIN_SMALL))
                            sum9_reg[c] <= sum9_reg[c] + SUM_W'(chan(rd_data_reg, c));
                    end
                    if (!cur_reg.filt)
                    begin
                        best9_reg  <= rd_data_reg;
                        best13_reg <= rd_data_reg;
                    end
                end
            end
            B_MEAN:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    mean9_reg[c*CH_W +: CH_W] <= CH_W'((PROD_W'(sum9_reg[c])
                        * PROD_W'(RECIP_SMALL)) >> RECIP_SH);
                    mean13_reg[c*CH_W +: CH_W] <= CH_W'((PROD_W'(sum13_reg[c])
                        * PROD_W'(RECIP_LARGE)) >> RECIP_SH);
                end
            end
            B_SCAN:
            begin
                for (int i = 0; i < WIN_LARGE - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                if ((cnt_reg == 4'd0) || ((cnt_reg < 4'(WIN_SMALL)) && (d9 < bd9_reg)))
                begin
                    bd9_reg   <= d9;
                    best9_reg <= win_reg[0];
                end
                if ((cnt_reg == 4'd0) || (d13 < bd13_reg))
                begin
                    bd13_reg   <= d13;
                    best13_reg <= win_reg[0];
                end
            end
            default:
            begin
            end
        endcase
        if ((state_reg == B_DONE) && out_free)
        begin
            out_pix_reg  <= res;
            out_last_reg <= cur_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 4'd1;
            if ((state_reg == B_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> hdl/ntmpd_checker.sv
module ntmpd_checker
    import ntmpd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_we,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [PIX_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);

    // stalled output transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // input held while the position divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_axis_tready)
        else $error("input ready right after register write");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> ##3 !s_axis_tready)
        else $error("input ready during resync");

    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid out of reset");

endmodule

bind nearest_to_mean_pixel_denoise_unit ntmpd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_top.sv
module tb_top;
    import ntmpd_pkg::*;

    // expected output pixel with its frame end mark
    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             last;
    } out_pixel_t;

    // scoreboard: keeps its own copy of the frame ring and the counters and
    // predicts each output transfer from the accepted input transfers
    class pixel_scoreboard;
        logic [PIX_W-1:0] ring [RING_ROWS*DEF_MAX_WIDTH];
        logic [PIX_W-1:0] win [WIN_LARGE];
        int               col;
        int               row;
        int               out_pos;
        int               width_reg;
        int               height_reg;
        out_pixel_t       expected_pixels [$];
        int               errors;

        function new();
            col        = 0;
            row        = 0;
            out_pos    = 0;
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            errors     = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = int'(val[IMG_W_W-1:0]);
            else
                height_reg = int'(val[IMG_H_W-1:0]);
        endfunction

        function int ring_slot(int r, int c);
            return (r & (RING_ROWS - 1)) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH);
        endfunction

        // first window entry with least L1 distance to the floor mean
        function int nearest_to_mean(int n);
            int sum [3];
            int mean [3];
            int best;
            int best_d;
            int d;
            int v;
            for (int c = 0; c < 3; c++)
            begin
                sum[c] = 0;
                for (int k = 0; k < n; k++)
                    sum[c] += int'(win[k][c*CH_W +: CH_W]);
                mean[c] = sum[c] / n;
            end
            best   = 0;
            best_d = 0;
            for (int k = 0; k < n; k++)
            begin
                d = 0;
                for (int c = 0; c < 3; c++)
                begin
                    v = int'(win[k][c*CH_W +: CH_W]);
                    d += (v > mean[c]) ? v - mean[c] : mean[c] - v;
                end
                if (k == 0 || d < best_d)
                begin
                    best_d = d;
                    best   = k;
                end
            end
            return best;
        endfunction

        function logic [PIX_W-1:0] denoise(int i, int j);
            int               k;
            int               a;
            int               b;
            logic [PIX_W-1:0] res;
            k = 0;
            for (int r = i - 1; r <= i + 1; r++)
                for (int q = j - 1; q <= j + 1; q++)
                begin
                    win[k] = ring[ring_slot(r, q)];
                    k++;
                end
            win[9]  = ring[ring_slot(i - 2, j)];
            win[10] = ring[ring_slot(i + 2, j)];
            win[11] = ring[ring_slot(i, j - 2)];
            win[12] = ring[ring_slot(i, j + 2)];
            a = nearest_to_mean(WIN_SMALL);
            b = nearest_to_mean(WIN_LARGE);
            for (int c = 0; c < 3; c++)
                res[c*CH_W +: CH_W] = CH_W'((int'(win[a][c*CH_W +: CH_W])
                                            + int'(win[b][c*CH_W +: CH_W])) >> 1);
            return res;
        endfunction

        function void note_pixel_transfer(logic [PIX_W-1:0] d, logic filler);
            int         w;
            int         h;
            int         total;
            int         pos_in;
            int         i;
            int         j;
            out_pixel_t e;
            w = width_reg;
            h = height_reg;
            if (w < MIN_SIDE) w = MIN_SIDE;
            if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
            if (h < MIN_SIDE) h = MIN_SIDE;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            total = w * h;
            if (out_pos >= total)
            begin
                col = 0; row = 0; out_pos = 0;
            end
            if (col >= w)
            begin
                col = 0;
                row++;
            end
            pos_in = row * w + col;
            if (pos_in < total)
            begin
                // filler inside the frame changes nothing
                if (filler)
                    return;
                ring[ring_slot(row, col)] = d;
            end
            if (col + 1 >= w)
            begin
                col = 0;
                row++;
            end
            else
                col++;
            if (pos_in < 2 * w + 2)
                return;
            i = out_pos / w;
            j = out_pos % w;
            if (i >= 2 && i + 2 < h && j >= 2 && j + 2 < w)
                e.pix = denoise(i, j);
            else
                e.pix = ring[ring_slot(i, j)];
            ring[ring_slot(i, j)] = e.pix;
            out_pos++;
            e.last = (out_pos >= total);
            if (e.last)
            begin
                col = 0; row = 0; out_pos = 0;
            end
            expected_pixels.push_back(e);
        endfunction

        function void check_output_transfer(logic [PIX_W-1:0] d, logic last);
            out_pixel_t e;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output transfer: data %h last %b", d, last);
                return;
            end
            e = expected_pixels.pop_front();
            if (d !== e.pix || last !== e.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected data %h last %b, got data %h last %b",
                             e.pix, e.last, d, last);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata;   // blue_in, green_in, red_in
    logic                  s_axis_tuser;   // filler
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;   // blue_out, green_out, red_out
    logic                  m_axis_tlast;   // frame_end

    pixel_scoreboard sb;
    bit              quiet;        // no gaps on either side
    bit              hold_req;     // asks the receiver for a long hold-off
    int              random_items;
    int              frame_w;
    int              frame_h;

    nearest_to_mean_pixel_denoise_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // safety net against a hung handshake
    initial
    begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // pixel content by pattern: random, saturated channels, near-flat (ties)
    function automatic logic [PIX_W-1:0] make_pixel(int pattern);
        logic [PIX_W-1:0] p;
        case (pattern)
            1: p = {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                    {8{1'($urandom_range(0, 1))}}};
            2: p = {8'(120 + $urandom_range(0, 2)), 8'(120 + $urandom_range(0, 2)),
                    8'(120 + $urandom_range(0, 2))};
            default: p = PIX_W'($urandom);
        endcase
        return p;
    endfunction

    // receiver: random stalls, and a long hold-off on request
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_output_transfer(m_axis_tdata, m_axis_tlast);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 15)
            begin
                stall_left = pick_gap();
                m_axis_tready <= (stall_left == 0);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, CFG_DATA_W'(val));
    endtask

    // one input transfer; tvalid only drops when a gap follows
    task automatic send_item(logic [PIX_W-1:0] d, logic filler);
        int g;
        g = pick_gap();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= filler;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel_transfer(d, filler);
    endtask

    // wait until every expected transfer is out, then let the back end settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // whole frame: pixels with stray fillers, then the flush with stray pixels
    task automatic run_frame(int w, int h, int pattern, bit noisy, bit pressure);
        int total;
        total = w * h;
        for (int k = 0; k < total; k++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(make_pixel(0), 1'b1);      // ignored filler
            if (pressure && k == total / 3)
                hold_req = 1'b1;                     // sender keeps offering
            if (pressure && k == (2 * total) / 3)
            begin
                s_axis_tvalid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            send_item(make_pixel(pattern), 1'b0);
        end
        for (int k = 0; k < 2 * w + 2; k++)
        begin
            // past the frame end a pixel is treated like a filler: not stored, only flushing
            if (noisy && $urandom_range(0, 3) == 0)
                send_item(make_pixel(0), 1'b0);
            else
                send_item(make_pixel(0), 1'b1);
        end
        drain();
    endtask

    initial
    begin
        sb            = new();
        quiet         = 1'b0;
        hold_req      = 1'b0;
        random_items  = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_IMAGE_WIDTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // smallest frame, saturated channels, stray fillers and pixels
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 5);
        run_frame(5, 5, 1, 1'b1, 1'b0);

        // out of range sizes saturate to the minimum; near-flat data for ties
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 0);
        run_frame(5, 5, 2, 1'b1, 1'b0);

        // long receiver hold-off and a sender pause mid frame
        write_reg(REG_IMAGE_WIDTH, 9);
        write_reg(REG_IMAGE_HEIGHT, 8);
        run_frame(9, 8, 0, 1'b1, 1'b1);

        // random small frames with random content, some without gaps
        while (random_items < 340)
        begin
            quiet   = ($urandom_range(0, 4) == 0);
            frame_w = $urandom_range(5, 12);
            frame_h = $urandom_range(5, 9);
            write_reg(REG_IMAGE_WIDTH, frame_w);
            write_reg(REG_IMAGE_HEIGHT, frame_h);
            run_frame(frame_w, frame_h, $urandom_range(0, 2), 1'b1, 1'b0);
            random_items += frame_w * frame_h + 2 * frame_w + 2;
        end

        quiet = 1'b0;
        drain();
        if (sb.pending() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
